/* rtl/bounded_deque_engine_assert.svh */
// Assertion macros for the deque engine.
`ifndef BOUNDED_DEQUE_ENGINE_ASSERT_SVH
`define BOUNDED_DEQUE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define BDE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bounded_deque_engine: same-cycle check failed");

// Next-cycle implication.
`define BDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bounded_deque_engine: next-cycle check failed");

`endif

/* rtl/bde_pkg.sv */
`timescale 1ns / 1ps

package bde_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam int FUNC_W = 3;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [FUNC_W-1:0]        func_type;
   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [STAT_W-1:0]        stat_type;

   localparam func_type FN_PUSH_FRONT = 3'd0;
   localparam func_type FN_PUSH_BACK  = 3'd1;
   localparam func_type FN_POP_FRONT  = 3'd2;
   localparam func_type FN_POP_BACK   = 3'd3;
   localparam func_type FN_DUMP       = 3'd4;

   localparam stat_type STAT_OK    = 2'd0;
   localparam stat_type STAT_FULL  = 2'd1;
   localparam stat_type STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      word_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } mem_req_type;

   function automatic idx_type idx_inc(input idx_type i);
      idx_inc = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic idx_type idx_dec(input idx_type i);
      idx_dec = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
   endfunction

   function automatic idx_type idx_add(input idx_type i, input cnt_type c);
      logic [SUM_W-1:0] s;
      s = SUM_W'(i) + SUM_W'(c);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      idx_add = s[IDX_W-1:0];
   endfunction

endpackage

/* rtl/bde_mem.sv */
`timescale 1ns / 1ps

module bde_mem
   import bde_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output word_type    rd_data
);

   word_type mem_ff [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bde_ctrl.sv */
`timescale 1ns / 1ps

module bde_ctrl
   import bde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  func_type    req_func,
   input  word_type    req_value,
   output mem_req_type mem_req,
   input  word_type    rd_data,
   output logic        rsp_valid,
   output word_type    rsp_value_out,
   output stat_type    rsp_status,
   output logic        rsp_last
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic     state_ff, state_in;
   idx_type  front_ff, front_in;
   cnt_type  count_ff, count_in;
   idx_type  idx_ff, idx_in;
   cnt_type  left_ff, left_in;
   logic     valid_ff, valid_in;
   logic     beat_ff, beat_in;
   stat_type status_ff, status_in;
   logic     last_ff, last_in;
   logic     accept;

   assign busy   = (state_ff == S_DUMP);
   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      front_in        = front_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      left_in         = left_ff;
      valid_in        = 1'b0;
      beat_in         = 1'b0;
      status_in       = STAT_OK;
      last_in         = 1'b1;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = '0;
      mem_req.wr_data = req_value;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = idx_ff;

      if (state_ff == S_DUMP) begin
         mem_req.rd_en = 1'b1;
         valid_in      = 1'b1;
         beat_in       = 1'b1;
         last_in       = (left_ff == CNT_W'(1));
         idx_in        = idx_inc(idx_ff);
         left_in       = left_ff - CNT_W'(1);
         if (left_ff == CNT_W'(1)) begin
            state_in = S_IDLE;
         end
      end else if (accept) begin
         valid_in = 1'b1;
         case (req_func)
            FN_PUSH_FRONT: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = STAT_FULL;
               end else begin
                  front_in        = idx_dec(front_ff);
                  count_in        = count_ff + CNT_W'(1);
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = idx_dec(front_ff);
               end
            end
            FN_PUSH_BACK: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = STAT_FULL;
               end else begin
                  count_in        = count_ff + CNT_W'(1);
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = idx_add(front_ff, count_ff);
               end
            end
            FN_POP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  front_in = idx_inc(front_ff);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FN_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FN_DUMP: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = front_ff;
                  beat_in         = 1'b1;
                  last_in         = (count_ff == CNT_W'(1));
                  idx_in          = idx_inc(front_ff);
                  left_in         = count_ff - CNT_W'(1);
                  if (count_ff != CNT_W'(1)) begin
                     state_in = S_DUMP;
                  end
               end
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
         beat_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_value_out = beat_ff ? rd_data : '0;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

/* rtl/bounded_deque_engine.sv */
// Push and pop: one transaction per cycle while not busy, result in the cycle
// after acceptance. Dump of N stored words: busy while words remain to read,
// one result per cycle starting in the cycle after acceptance; throughput set
// by the single memory read port. Results cannot be stalled by the receiver.
// Synchronous active-high reset empties the deque; no clearing pass.
`timescale 1ns / 1ps

`include "bounded_deque_engine_assert.svh"

module bounded_deque_engine
   import bde_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  func_type req_func,
   input  word_type req_value,
   output logic     rsp_valid,
   output word_type rsp_value_out,
   output stat_type rsp_status,
   output logic     rsp_last
);

   mem_req_type mem_req;
   word_type    rd_data;

   bde_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   bde_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_value     (req_value),
      .mem_req       (mem_req),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   `BDE_ASSERT_NEXT(a_busy_gives_beat, clock, reset, busy, rsp_valid && (rsp_status == STAT_OK))
   `BDE_ASSERT_NEXT(a_single_result, clock, reset, start && !busy && (req_func != FN_DUMP), rsp_valid && rsp_last && !busy)
   `BDE_ASSERT_NOW(a_error_is_last, clock, reset, rsp_valid && (rsp_status != STAT_OK), rsp_last && (rsp_value_out == '0))
   `BDE_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, (rsp_status == STAT_OK) || (rsp_status == STAT_FULL) || (rsp_status == STAT_EMPTY))

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import bde_pkg::*;

   localparam func_type FN_UNUSED_LO = FN_DUMP + 3'd1;
   localparam func_type FN_UNUSED_HI = '1;
   localparam int       CYCLE_LIMIT  = 200000;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;

   typedef struct packed {
      word_type value_out;
      stat_type status;
      logic     last;
   } deque_result_type;

   class deque_scoreboard;
      word_type         slots[DEPTH];
      int               head;
      int               fill;
      deque_result_type exp_q[$];
      int               errors;
      int               requests;
      int               results;
      int               peak_fill;
      int               full_hits;
      int               empty_hits;
      int               unused_hits;

      function new();
         head = 0;
         fill = 0;
         errors = 0;
         requests = 0;
         results = 0;
         peak_fill = 0;
         full_hits = 0;
         empty_hits = 0;
         unused_hits = 0;
      endfunction

      function int pending();
         return exp_q.size();
      endfunction

      function void add_result(word_type v, stat_type s, logic l);
         deque_result_type r;
         r.value_out = v;
         r.status = s;
         r.last = l;
         exp_q.push_back(r);
      endfunction

      // Predict the results of one accepted transaction and update state.
      function void note_request(func_type f, word_type v);
         requests++;
         case (f)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
               if (fill >= DEPTH) begin
                  full_hits++;
                  add_result('0, STAT_FULL, 1'b1);
               end else begin
                  if (f == FN_PUSH_FRONT) begin
                     head = (head == 0) ? DEPTH - 1 : head - 1;
                     slots[head] = v;
                  end else begin
                     slots[(head + fill) % DEPTH] = v;
                  end
                  fill++;
                  if (fill > peak_fill) peak_fill = fill;
                  add_result('0, STAT_OK, 1'b1);
               end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
               if (fill == 0) begin
                  empty_hits++;
                  add_result('0, STAT_EMPTY, 1'b1);
               end else begin
                  if (f == FN_POP_FRONT) head = (head + 1) % DEPTH;
                  fill--;
                  add_result('0, STAT_OK, 1'b1);
               end
            end
            FN_DUMP: begin
               if (fill == 0) begin
                  empty_hits++;
                  add_result('0, STAT_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < fill; i++) begin
                     add_result(slots[(head + i) % DEPTH], STAT_OK, (i == fill - 1));
                  end
               end
            end
            default: begin
               unused_hits++;
               add_result('0, STAT_OK, 1'b1);
            end
         endcase
      endfunction

      function void check_result(word_type v, stat_type s, logic l);
         deque_result_type e;
         results++;
         if (exp_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value_out=%h status=%0d last=%0b",
                     $time, v, s, l);
            return;
         end
         e = exp_q.pop_front();
         if (v !== e.value_out) begin
            errors++;
            $display("%0t: value_out mismatch: expected %h, actual %h",
                     $time, e.value_out, v);
         end
         if (s !== e.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, e.status, s);
         end
         if (l !== e.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, e.last, l);
         end
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   func_type req_func;
   word_type req_value;
   logic     rsp_valid;
   word_type rsp_value_out;
   stat_type rsp_status;
   logic     rsp_last;

   deque_scoreboard sb;
   int              cycle_count;
   int              burst_left;
   bit              steady;

   bounded_deque_engine dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_func, req_value);
         if (rsp_valid) sb.check_result(rsp_value_out, rsp_status, rsp_last);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input func_type f, input word_type v);
      start = 1'b1;
      req_func = f;
      req_value = v;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle(input int n);
      start = 1'b0;
      req_func = func_type'($urandom);
      req_value = word_type'($urandom);
      repeat (n) @(negedge clock);
   endtask

   task automatic paced_send(input func_type f, input word_type v);
      if (burst_left == 0) begin
         if (!steady) idle($urandom_range(1, 5));
         burst_left = $urandom_range(1, 8);
      end
      send_request(f, v);
      burst_left--;
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic word_type pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return '1;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic func_type pick_func(input phase_type ph);
      int r;
      int push_w;
      int pop_w;
      r = $urandom_range(0, 99);
      case (ph)
         PH_FILL: begin
            push_w = 88;
            pop_w = 4;
         end
         PH_DRAIN: begin
            push_w = 10;
            pop_w = 75;
         end
         default: begin
            push_w = 30;
            pop_w = 30;
         end
      endcase
      if (r < push_w) return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      if (r < push_w + pop_w) return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
      if (r < 93) return FN_DUMP;
      return func_type'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
   endfunction

   initial begin
      int guard;
      sb = new();
      cycle_count = 0;
      burst_left = 0;
      steady = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_func = FN_PUSH_FRONT;
      req_value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty cases, undefined codes, extremes, single-entry pops
      send_request(FN_DUMP, '0);
      send_request(FN_POP_FRONT, '0);
      send_request(FN_POP_BACK, '0);
      for (int c = FN_UNUSED_LO; c <= FN_UNUSED_HI; c++) send_request(func_type'(c), '1);
      send_request(FN_PUSH_FRONT, 32'sh7fffffff);
      send_request(FN_PUSH_BACK, 32'sh80000000);
      send_request(FN_PUSH_FRONT, '0);
      send_request(FN_DUMP, '1);
      send_request(FN_POP_FRONT, '1);
      send_request(FN_POP_BACK, '0);
      send_request(FN_POP_BACK, '0);
      send_request(FN_POP_BACK, '0);
      send_request(FN_DUMP, '0);
      send_request(FN_PUSH_BACK, '1);
      send_request(FN_PUSH_FRONT, 32'sh00000001);
      send_request(FN_DUMP, '0);
      send_request(FN_POP_FRONT, '0);
      send_request(FN_POP_FRONT, '0);
      send_request(FN_DUMP, '0);
      wait_drained();

      // grow to full, hit the full case, dump the whole store
      guard = 0;
      while (sb.fill < DEPTH && guard < 400) begin
         paced_send(pick_func(PH_FILL), pick_value());
         guard++;
      end
      repeat (3) paced_send($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT,
                            pick_value());
      paced_send(FN_DUMP, pick_value());
      wait_drained();

      // partial drain, first stretch back-to-back
      steady = 1'b1;
      guard = 0;
      while (sb.fill > 0 && guard < 8) begin
         if (guard == 5) steady = 1'b0;
         paced_send(pick_func(PH_DRAIN), pick_value());
         guard++;
      end
      steady = 1'b0;

      for (int n = 0; n < 4; n++) paced_send(pick_func(PH_MIXED), pick_value());

      wait_drained();
      repeat (8) @(negedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
      end
      $display("Ran %0d transactions, checked %0d results; peak fill %0d of %0d.",
               sb.requests, sb.results, sb.peak_fill, DEPTH);
      $display("Full pushes %0d, empty pops/dumps %0d, undefined codes %0d.",
               sb.full_hits, sb.empty_hits, sb.unused_hits);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
